FILE: rtl/rcsci_pkg.sv
// Shared types and constants for the RC stick command interpreter.
// Holds register indexes, reset values, mode codes and the sequencer states.
// Depends on nothing; the divider and the core both use it.
`default_nettype none

package rcsci_pkg;

	// Default timing and switch threshold values for the top level parameters.
	localparam int unsigned REFRESH_PERIOD_US_DEF   = 20000;
	localparam int unsigned SWITCH_THRESHOLD_US_DEF = 1500;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_FIXED_WING         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STICK_CENTER       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_RANGE        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_BOTTOM    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ANGLE          = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE           = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERRIDE_DEVIATION = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERRIDE_LAG_MS    = 3'd7;

	// Register reset values.
	localparam logic        FIXED_WING_RST         = 1'b0;
	localparam logic [11:0] STICK_CENTER_RST       = 12'd1500;
	localparam logic [11:0] PULSE_RANGE_RST        = 12'd1000;
	localparam logic [11:0] THROTTLE_BOTTOM_RST    = 12'd1000;
	localparam logic [13:0] MAX_ANGLE_RST          = 14'd3219;
	localparam logic [16:0] MAX_RATE_RST           = 17'd12868;
	localparam logic [11:0] OVERRIDE_DEVIATION_RST = 12'd100;
	localparam logic [15:0] OVERRIDE_LAG_MS_RST    = 16'd1000;

	// Attitude and yaw mode codes.
	localparam logic [1:0] MODE_ANGLE = 2'd0;
	localparam logic [1:0] MODE_RATE  = 2'd1;
	localparam logic [1:0] MODE_PASS  = 2'd2;

	// Axis order through the shared divider.
	localparam logic [1:0] AXIS_ROLL     = 2'd0;
	localparam logic [1:0] AXIS_PITCH    = 2'd1;
	localparam logic [1:0] AXIS_YAW      = 2'd2;
	localparam logic [1:0] AXIS_THROTTLE = 2'd3;

	// Throttle scale: thousandths of the span.
	localparam logic [17:0] THROTTLE_SCALE = 18'd1000;

	// Microseconds per millisecond for the override lag window.
	localparam logic [25:0] US_PER_MS = 26'd1000;

	// Divider geometry: magnitudes of all products fit in 30 bits.
	localparam int DIV_W     = 30;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int DIVISOR_W = 12;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_START,
		ST_WAIT,
		ST_OUT
	} rcsci_state_t;

endpackage

`default_nettype wire

FILE: rtl/rc_stick_command_interpreter_core.sv
// Top level of the RC stick command interpreter: rate limit, modes, override and scaling.
// Uses rcsci_pkg and the bit-serial divider rcsci_div.
//
// Channel  Direction  Handshake              Content
// in       receive    in_valid / in_stall    timestamp and eight pulse widths
// out      send       out_valid / out_stall  four commands, three modes, two flags
// cfg      receive    cfg_valid / cfg_ready  register index and write data
//
// One sample is taken at a time. A sample inside the refresh period is dropped in the
// check state, and the sequencer goes back to idle to take the next sample.
// An accepted sample runs four products through the one serial divider, one after another,
// and no new sample is taken until its result is loaded into the output register.
// The finished result waits in the output register while the next sample is taken.
// Reset restores the registers to their defaults and clears both time stamps.
`default_nettype none

module rc_stick_command_interpreter_core #(
	parameter int unsigned REFRESH_PERIOD_US   = rcsci_pkg::REFRESH_PERIOD_US_DEF,
	parameter int unsigned SWITCH_THRESHOLD_US = rcsci_pkg::SWITCH_THRESHOLD_US_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Sample requests.
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [31:0]                          now_us,
	input  wire logic [11:0]                          roll_pulse,
	input  wire logic [11:0]                          pitch_pulse,
	input  wire logic [11:0]                          yaw_pulse,
	input  wire logic [11:0]                          throttle_pulse,
	input  wire logic [11:0]                          attitude_mode_pulse,
	input  wire logic [11:0]                          throttle_mode_pulse,
	input  wire logic [11:0]                          attitude_override_pulse,
	input  wire logic [11:0]                          throttle_override_pulse,
	// Command requests.
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [23:0]                        roll_command,
	output logic signed [23:0]                        pitch_command,
	output logic signed [23:0]                        yaw_command,
	output logic signed [15:0]                        throttle_command,
	output logic [1:0]                                attitude_mode,
	output logic [1:0]                                yaw_mode,
	output logic                                      throttle_mode,
	output logic                                      attitude_active,
	output logic                                      throttle_active,
	// Register writes.
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rcsci_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [rcsci_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [31:0] REFRESH_US = 32'(REFRESH_PERIOD_US);
	localparam logic [11:0] SWITCH_US  = 12'(SWITCH_THRESHOLD_US);

	// Configuration registers.
	logic        fixed_wing_q;
	logic [11:0] stick_center_q;
	logic [11:0] pulse_range_q;
	logic [11:0] throttle_bottom_q;
	logic [13:0] max_angle_q;
	logic [16:0] max_rate_q;
	logic [11:0] override_deviation_q;
	logic [15:0] override_lag_ms_q;

	// Time stamps.
	logic [31:0] last_accept_q;
	logic [31:0] last_dev_q;

	// Sample held for the duration of the work.
	logic [31:0] now_q;
	logic [11:0] roll_q, pitch_q, yaw_q, thr_q;
	logic [11:0] att_sw_q, thr_sw_q, att_ovr_q, thr_ovr_q;

	// Working values.
	rcsci_pkg::rcsci_state_t state_q, state_d;
	logic [1:0]         axis_q;
	logic signed [12:0] dr_q, dp_q, dy_q, dt_q;
	logic [1:0]         amode_q, ymode_q;
	logic               tmode_q, aact_q, tact_q;
	logic [rcsci_pkg::DIV_W-1:0] prod_q;
	logic               neg_q;
	logic signed [23:0] rc_q, pc_q, yc_q;
	logic signed [15:0] tc_q;

	// Output register.
	logic               out_valid_q;
	logic signed [23:0] roll_cmd_q, pitch_cmd_q, yaw_cmd_q;
	logic signed [15:0] thr_cmd_q;
	logic [1:0]         att_mode_q, yaw_mode_q;
	logic               thr_mode_q, att_act_q, thr_act_q;

	// Sequencer outputs.
	logic in_take;
	logic div_start;
	logic out_load;

	// Divider interface.
	logic                        div_done;
	logic [rcsci_pkg::DIV_W-1:0] div_quot;
	logic [11:0]                 range_eff;

	// Check-stage values.
	logic [31:0]        since_accept, since_dev;
	logic               accept_ok, in_lag, att_sw_hi;
	logic [25:0]        lag_us;
	logic signed [12:0] dr_c, dp_c, dy_c, dt_c;
	logic [12:0]        dr_abs, dp_abs, dy_abs;
	logic               stick_moved;

	// Multiply-stage values.
	logic signed [12:0] mul_dev;
	logic [12:0]        mul_abs;
	logic [17:0]        mul_scale;
	logic [rcsci_pkg::DIV_W-1:0] mul_prod;

	// Saturation of the divider result.
	logic [rcsci_pkg::DIV_W-1:0] quot_neg;
	logic signed [23:0] sat24;
	logic signed [15:0] sat16;

	assign cfg_ready = 1'b1;

	// Register writes are taken in any cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_wing_q         <= rcsci_pkg::FIXED_WING_RST;
			stick_center_q       <= rcsci_pkg::STICK_CENTER_RST;
			pulse_range_q        <= rcsci_pkg::PULSE_RANGE_RST;
			throttle_bottom_q    <= rcsci_pkg::THROTTLE_BOTTOM_RST;
			max_angle_q          <= rcsci_pkg::MAX_ANGLE_RST;
			max_rate_q           <= rcsci_pkg::MAX_RATE_RST;
			override_deviation_q <= rcsci_pkg::OVERRIDE_DEVIATION_RST;
			override_lag_ms_q    <= rcsci_pkg::OVERRIDE_LAG_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcsci_pkg::REG_FIXED_WING:         fixed_wing_q         <= cfg_data[0];
				rcsci_pkg::REG_STICK_CENTER:       stick_center_q       <= cfg_data[11:0];
				rcsci_pkg::REG_PULSE_RANGE:        pulse_range_q        <= cfg_data[11:0];
				rcsci_pkg::REG_THROTTLE_BOTTOM:    throttle_bottom_q    <= cfg_data[11:0];
				rcsci_pkg::REG_MAX_ANGLE:          max_angle_q          <= cfg_data[13:0];
				rcsci_pkg::REG_MAX_RATE:           max_rate_q           <= cfg_data[16:0];
				rcsci_pkg::REG_OVERRIDE_DEVIATION: override_deviation_q <= cfg_data[11:0];
				rcsci_pkg::REG_OVERRIDE_LAG_MS:    override_lag_ms_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A zero span is treated as one.
	assign range_eff = (pulse_range_q == '0) ? 12'd1 : pulse_range_q;

	// Rate limit, stick deviations and the override lag window.
	assign since_accept = now_q - last_accept_q;
	assign accept_ok    = since_accept >= REFRESH_US;
	assign lag_us       = 26'(override_lag_ms_q) * rcsci_pkg::US_PER_MS;
	assign since_dev    = now_q - last_dev_q;
	assign in_lag       = since_dev < {6'b0, lag_us};
	assign att_sw_hi    = att_sw_q > SWITCH_US;

	assign dr_c = $signed({1'b0, roll_q})  - $signed({1'b0, stick_center_q});
	assign dp_c = $signed({1'b0, pitch_q}) - $signed({1'b0, stick_center_q});
	assign dy_c = $signed({1'b0, yaw_q})   - $signed({1'b0, stick_center_q});
	assign dt_c = $signed({1'b0, thr_q})   - $signed({1'b0, throttle_bottom_q});

	assign dr_abs = dr_c[12] ? 13'(-dr_c) : 13'(dr_c);
	assign dp_abs = dp_c[12] ? 13'(-dp_c) : 13'(dp_c);
	assign dy_abs = dy_c[12] ? 13'(-dy_c) : 13'(dy_c);

	assign stick_moved = (dr_abs > {1'b0, override_deviation_q}) ||
		(dp_abs > {1'b0, override_deviation_q}) ||
		(dy_abs > {1'b0, override_deviation_q});

	// Pick the deviation and the scale for the axis in work.
	always_comb begin
		case (axis_q)
			rcsci_pkg::AXIS_ROLL: begin
				mul_dev   = dr_q;
				mul_scale = (amode_q == rcsci_pkg::MODE_ANGLE) ?
					{3'b0, max_angle_q, 1'b0} : {max_rate_q, 1'b0};
			end
			rcsci_pkg::AXIS_PITCH: begin
				mul_dev   = dp_q;
				mul_scale = (amode_q == rcsci_pkg::MODE_ANGLE) ?
					{3'b0, max_angle_q, 1'b0} : {max_rate_q, 1'b0};
			end
			rcsci_pkg::AXIS_YAW: begin
				mul_dev   = dy_q;
				mul_scale = {max_rate_q, 1'b0};
			end
			default: begin
				mul_dev   = dt_q;
				mul_scale = rcsci_pkg::THROTTLE_SCALE;
			end
		endcase
	end

	assign mul_abs  = mul_dev[12] ? 13'(-mul_dev) : 13'(mul_dev);
	assign mul_prod = {18'b0, mul_abs[11:0]} * {12'b0, mul_scale};

	// Truncated quotient gets its sign back, then saturates to the field width.
	assign quot_neg = '0 - div_quot;

	always_comb begin
		if (neg_q) begin
			sat24 = (div_quot > 30'h0080_0000) ? 24'sh80_0000 : $signed(quot_neg[23:0]);
			sat16 = (div_quot > 30'h0000_8000) ? 16'sh8000 : $signed(quot_neg[15:0]);
		end else begin
			sat24 = (div_quot > 30'h007F_FFFF) ? 24'sh7F_FFFF : $signed(div_quot[23:0]);
			sat16 = (div_quot > 30'h0000_7FFF) ? 16'sh7FFF : $signed(div_quot[15:0]);
		end
	end

	rcsci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (range_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcsci_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		in_take   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			rcsci_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					in_take = 1'b1;
					state_d = rcsci_pkg::ST_CHECK;
				end
			end
			rcsci_pkg::ST_CHECK: begin
				state_d = accept_ok ? rcsci_pkg::ST_MUL : rcsci_pkg::ST_IDLE;
			end
			rcsci_pkg::ST_MUL: begin
				state_d = rcsci_pkg::ST_START;
			end
			rcsci_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = rcsci_pkg::ST_WAIT;
			end
			rcsci_pkg::ST_WAIT: begin
				if (div_done) begin
					state_d = (axis_q == rcsci_pkg::AXIS_THROTTLE) ?
						rcsci_pkg::ST_OUT : rcsci_pkg::ST_MUL;
				end
			end
			rcsci_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = rcsci_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rcsci_pkg::ST_IDLE;
			end
		endcase
	end

	// Time stamps and the axis counter are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_accept_q <= '0;
			last_dev_q    <= '0;
			axis_q        <= rcsci_pkg::AXIS_ROLL;
		end else begin
			if (state_q == rcsci_pkg::ST_CHECK && accept_ok) begin
				last_accept_q <= now_q;
				axis_q        <= rcsci_pkg::AXIS_ROLL;
				if (!(att_ovr_q > SWITCH_US) && !in_lag && stick_moved) begin
					last_dev_q <= now_q;
				end
			end
			if (state_q == rcsci_pkg::ST_WAIT && div_done) begin
				axis_q <= axis_q + 2'd1;
			end
		end
	end

	// Sample capture, mode decode and the per-axis results.
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q     <= now_us;
			roll_q    <= roll_pulse;
			pitch_q   <= pitch_pulse;
			yaw_q     <= yaw_pulse;
			thr_q     <= throttle_pulse;
			att_sw_q  <= attitude_mode_pulse;
			thr_sw_q  <= throttle_mode_pulse;
			att_ovr_q <= attitude_override_pulse;
			thr_ovr_q <= throttle_override_pulse;
		end
		if (state_q == rcsci_pkg::ST_CHECK) begin
			dr_q <= dr_c;
			dp_q <= dp_c;
			dy_q <= dy_c;
			dt_q <= dt_c;
			if (fixed_wing_q) begin
				amode_q <= rcsci_pkg::MODE_PASS;
				ymode_q <= rcsci_pkg::MODE_PASS;
				tmode_q <= 1'b0;
			end else begin
				amode_q <= att_sw_hi ? rcsci_pkg::MODE_ANGLE : rcsci_pkg::MODE_RATE;
				ymode_q <= rcsci_pkg::MODE_RATE;
				tmode_q <= thr_sw_q > SWITCH_US;
			end
			aact_q <= (att_ovr_q > SWITCH_US) || in_lag || stick_moved;
			tact_q <= thr_ovr_q > SWITCH_US;
		end
		if (state_q == rcsci_pkg::ST_MUL) begin
			prod_q <= mul_prod;
			neg_q  <= mul_dev[12];
		end
		if (state_q == rcsci_pkg::ST_WAIT && div_done) begin
			case (axis_q)
				rcsci_pkg::AXIS_ROLL:  rc_q <= sat24;
				rcsci_pkg::AXIS_PITCH: pc_q <= sat24;
				rcsci_pkg::AXIS_YAW:   yc_q <= sat24;
				default:               tc_q <= sat16;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; passthrough axes carry the raw deviation.
	always_ff @(posedge clk) begin
		if (out_load) begin
			roll_cmd_q  <= (amode_q == rcsci_pkg::MODE_PASS) ?
				{{11{dr_q[12]}}, dr_q} : rc_q;
			pitch_cmd_q <= (amode_q == rcsci_pkg::MODE_PASS) ?
				{{11{dp_q[12]}}, dp_q} : pc_q;
			yaw_cmd_q   <= (ymode_q == rcsci_pkg::MODE_PASS) ?
				{{11{dy_q[12]}}, dy_q} : yc_q;
			thr_cmd_q   <= tc_q;
			att_mode_q  <= amode_q;
			yaw_mode_q  <= ymode_q;
			thr_mode_q  <= tmode_q;
			att_act_q   <= aact_q;
			thr_act_q   <= tact_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign roll_command     = roll_cmd_q;
	assign pitch_command    = pitch_cmd_q;
	assign yaw_command      = yaw_cmd_q;
	assign throttle_command = thr_cmd_q;
	assign attitude_mode    = att_mode_q;
	assign yaw_mode         = yaw_mode_q;
	assign throttle_mode    = thr_mode_q;
	assign attitude_active  = att_act_q;
	assign throttle_active  = thr_act_q;

endmodule

`default_nettype wire

FILE: rtl/rcsci_div.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Uses rcsci_pkg for its widths; instantiated by the interpreter core.
`default_nettype none

module rcsci_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [rcsci_pkg::DIV_W-1:0]       dividend,
	input  wire logic [rcsci_pkg::DIVISOR_W-1:0]   divisor,
	output logic                                   done,
	output logic [rcsci_pkg::DIV_W-1:0]            quotient
);

	localparam int W  = rcsci_pkg::DIV_W;
	localparam int DW = rcsci_pkg::DIVISOR_W;
	localparam int CW = rcsci_pkg::DIV_CNT_W;

	logic [W-1:0]  work_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW+1:0] diff;
	logic          qbit;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign diff = {1'b0, rem_q, work_q[W-1]} - {2'b00, divisor};
	assign qbit = ~diff[DW+1];

	// Control: count the quotient bits and flag the cycle after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out at the top while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[W-2:0], qbit};
			rem_q  <= qbit ? diff[DW-1:0] : {rem_q[DW-2:0], work_q[W-1]};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

`default_nettype wire

FILE: verif/rc_stick_command_interpreter_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rc_stick_command_interpreter_core: drives samples and register
// writes, predicts each command request and compares it field by field. Depends on rcsci_pkg.

module rc_stick_command_interpreter_core_test;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 160;
	localparam int PHASE_ITEMS   = 104;

	typedef struct packed {
		logic [31:0] now;
		logic [11:0] roll;
		logic [11:0] pitch;
		logic [11:0] yaw;
		logic [11:0] throttle;
		logic [11:0] att_mode;
		logic [11:0] thr_mode;
		logic [11:0] att_ovr;
		logic [11:0] thr_ovr;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] roll;
		logic signed [23:0] pitch;
		logic signed [23:0] yaw;
		logic signed [15:0] throttle;
		logic [1:0]         att_mode;
		logic [1:0]         yaw_mode;
		logic               thr_mode;
		logic               att_active;
		logic               thr_active;
	} command_t;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rcsci_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [rcsci_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	sample_t drv_sample = '0;
	logic signed [23:0] roll_command;
	logic signed [23:0] pitch_command;
	logic signed [23:0] yaw_command;
	logic signed [15:0] throttle_command;
	logic [1:0] attitude_mode;
	logic [1:0] yaw_mode;
	logic throttle_mode;
	logic attitude_active;
	logic throttle_active;

	// Register copies used for prediction.
	logic        reg_fixed_wing = rcsci_pkg::FIXED_WING_RST;
	logic [11:0] reg_center     = rcsci_pkg::STICK_CENTER_RST;
	logic [11:0] reg_range      = rcsci_pkg::PULSE_RANGE_RST;
	logic [11:0] reg_bottom     = rcsci_pkg::THROTTLE_BOTTOM_RST;
	logic [13:0] reg_max_angle  = rcsci_pkg::MAX_ANGLE_RST;
	logic [16:0] reg_max_rate   = rcsci_pkg::MAX_RATE_RST;
	logic [11:0] reg_deviation  = rcsci_pkg::OVERRIDE_DEVIATION_RST;
	logic [15:0] reg_lag_ms     = rcsci_pkg::OVERRIDE_LAG_MS_RST;

	// Time stamps of the last accepted sample and the last stick deviation.
	logic [31:0] last_sample_us = '0;
	logic [31:0] last_stick_us  = '0;

	sample_t  sample_q[$];
	command_t expected_cmds[$];
	int sent_total = 0;
	int taken_total = 0;
	int seen_taken = 0;
	int mismatches = 0;
	int cycles = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit quiet = 1'b0;

	// Stimulus planning: the generator tracks which samples pass the refresh check.
	logic [31:0] plan_last_us = '0;
	logic [31:0] clock_us = '0;
	int plan_taken = 0;

	rc_stick_command_interpreter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_us(drv_sample.now),
		.roll_pulse(drv_sample.roll),
		.pitch_pulse(drv_sample.pitch),
		.yaw_pulse(drv_sample.yaw),
		.throttle_pulse(drv_sample.throttle),
		.attitude_mode_pulse(drv_sample.att_mode),
		.throttle_mode_pulse(drv_sample.thr_mode),
		.attitude_override_pulse(drv_sample.att_ovr),
		.throttle_override_pulse(drv_sample.thr_ovr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.roll_command(roll_command),
		.pitch_command(pitch_command),
		.yaw_command(yaw_command),
		.throttle_command(throttle_command),
		.attitude_mode(attitude_mode),
		.yaw_mode(yaw_mode),
		.throttle_mode(throttle_mode),
		.attitude_active(attitude_active),
		.throttle_active(throttle_active),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Scales a stick deviation to Q12 radians, truncating toward zero, then saturates.
	function automatic logic [23:0] axis_scale(longint dev, longint maxv, longint divisor);
		return 24'(clamp(dev * 2 * maxv / divisor, -8388608, 8388607));
	endfunction

	// Works out the command for one sample; returns 0 when the sample is rate limited.
	function automatic bit interpret_sample(input sample_t s, output command_t c);
		logic [31:0] lag_us;
		longint center, divisor, dr, dp, dy, dev;
		c = '0;
		if (s.now - last_sample_us < rcsci_pkg::REFRESH_PERIOD_US_DEF)
			return 1'b0;
		last_sample_us = s.now;

		if (reg_fixed_wing) begin
			c.att_mode = rcsci_pkg::MODE_PASS;
			c.yaw_mode = rcsci_pkg::MODE_PASS;
			c.thr_mode = 1'b0;
		end else begin
			c.att_mode = (s.att_mode > rcsci_pkg::SWITCH_THRESHOLD_US_DEF) ?
				rcsci_pkg::MODE_ANGLE : rcsci_pkg::MODE_RATE;
			c.yaw_mode = rcsci_pkg::MODE_RATE;
			c.thr_mode = (s.thr_mode > rcsci_pkg::SWITCH_THRESHOLD_US_DEF);
		end

		center = longint'(reg_center);
		divisor = (reg_range == 0) ? 1 : longint'(reg_range);
		dev = longint'(reg_deviation);
		dr = longint'(s.roll) - center;
		dp = longint'(s.pitch) - center;
		dy = longint'(s.yaw) - center;

		// Roll and pitch follow the attitude mode; yaw is rate or passthrough.
		if (c.att_mode == rcsci_pkg::MODE_ANGLE) begin
			c.roll = axis_scale(dr, longint'(reg_max_angle), divisor);
			c.pitch = axis_scale(dp, longint'(reg_max_angle), divisor);
		end else if (c.att_mode == rcsci_pkg::MODE_RATE) begin
			c.roll = axis_scale(dr, longint'(reg_max_rate), divisor);
			c.pitch = axis_scale(dp, longint'(reg_max_rate), divisor);
		end else begin
			c.roll = 24'(dr);
			c.pitch = 24'(dp);
		end
		c.yaw = (c.yaw_mode == rcsci_pkg::MODE_RATE) ?
			axis_scale(dy, longint'(reg_max_rate), divisor) : 24'(dy);
		c.throttle = 16'(clamp((longint'(s.throttle) - longint'(reg_bottom)) * 1000 / divisor,
			-32768, 32767));

		// The override holds while the switch is up or the lag window is open.
		lag_us = 32'(reg_lag_ms) * 32'd1000;
		if (s.att_ovr > rcsci_pkg::SWITCH_THRESHOLD_US_DEF ||
			(s.now - last_stick_us) < lag_us) begin
			c.att_active = 1'b1;
		end else begin
			c.att_active = magnitude(dr) > dev || magnitude(dp) > dev || magnitude(dy) > dev;
			if (c.att_active)
				last_stick_us = s.now;
		end
		c.thr_active = (s.thr_ovr > rcsci_pkg::SWITCH_THRESHOLD_US_DEF);
		return 1'b1;
	endfunction

	// Sample driver: holds a request until it is taken, with random idle bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || seen_taken != taken_total) begin
				seen_taken = taken_total;
				if (in_gap > 0) begin
					in_gap = in_gap - 1;
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					drv_sample <= sample_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end

			// Command side back-pressure in random bursts.
			if (out_gap > 0) begin
				out_gap = out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_gap = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: checks command requests and predicts on every taken sample.
	always @(posedge clk) begin
		command_t got, want;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** rc_stick_command_interpreter_core: FAILED **");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {roll_command, pitch_command, yaw_command, throttle_command,
					attitude_mode, yaw_mode, throttle_mode, attitude_active, throttle_active};
				if (expected_cmds.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected command at cycle %0d: roll %0d pitch %0d yaw %0d",
							cycles, got.roll, got.pitch, got.yaw);
					mismatches = mismatches + 1;
				end else begin
					want = expected_cmds.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$write("mismatch at cycle %0d (expected/actual): roll %0d/%0d ",
								cycles, want.roll, got.roll);
							$write("pitch %0d/%0d yaw %0d/%0d thr %0d/%0d amode %0d/%0d ",
								want.pitch, got.pitch, want.yaw, got.yaw,
								want.throttle, got.throttle, want.att_mode, got.att_mode);
							$display("ymode %0d/%0d tmode %0d/%0d aact %0d/%0d tact %0d/%0d",
								want.yaw_mode, got.yaw_mode, want.thr_mode, got.thr_mode,
								want.att_active, got.att_active,
								want.thr_active, got.thr_active);
						end
						mismatches = mismatches + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				taken_total = taken_total + 1;
				if (interpret_sample(drv_sample, want))
					expected_cmds.push_back(want);
			end
		end
	end

	task automatic push_sample(input logic [31:0] now, input logic [11:0] roll,
		input logic [11:0] pitch, input logic [11:0] yaw, input logic [11:0] thr,
		input logic [11:0] asw, input logic [11:0] tsw, input logic [11:0] aovr,
		input logic [11:0] tovr);
		sample_t s;
		s = '{now, roll, pitch, yaw, thr, asw, tsw, aovr, tovr};
		sample_q.push_back(s);
		sent_total = sent_total + 1;
		if (now - plan_last_us >= rcsci_pkg::REFRESH_PERIOD_US_DEF) begin
			plan_last_us = now;
			plan_taken = plan_taken + 1;
		end
		clock_us = now;
	endtask

	// Writes one register through the cfg handshake and mirrors it in the predictor.
	task automatic write_reg(input logic [rcsci_pkg::CFG_INDEX_W-1:0] idx,
		input int unsigned val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= rcsci_pkg::CFG_DATA_W'(val);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rcsci_pkg::REG_FIXED_WING:         reg_fixed_wing = val[0];
			rcsci_pkg::REG_STICK_CENTER:       reg_center = val[11:0];
			rcsci_pkg::REG_PULSE_RANGE:        reg_range = val[11:0];
			rcsci_pkg::REG_THROTTLE_BOTTOM:    reg_bottom = val[11:0];
			rcsci_pkg::REG_MAX_ANGLE:          reg_max_angle = val[13:0];
			rcsci_pkg::REG_MAX_RATE:           reg_max_rate = val[16:0];
			rcsci_pkg::REG_OVERRIDE_DEVIATION: reg_deviation = val[11:0];
			rcsci_pkg::REG_OVERRIDE_LAG_MS:    reg_lag_ms = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(input int unsigned fw, input int unsigned center,
		input int unsigned span, input int unsigned bottom, input int unsigned angle,
		input int unsigned rate, input int unsigned dev, input int unsigned lag);
		write_reg(rcsci_pkg::REG_FIXED_WING, fw);
		write_reg(rcsci_pkg::REG_STICK_CENTER, center);
		write_reg(rcsci_pkg::REG_PULSE_RANGE, span);
		write_reg(rcsci_pkg::REG_THROTTLE_BOTTOM, bottom);
		write_reg(rcsci_pkg::REG_MAX_ANGLE, angle);
		write_reg(rcsci_pkg::REG_MAX_RATE, rate);
		write_reg(rcsci_pkg::REG_OVERRIDE_DEVIATION, dev);
		write_reg(rcsci_pkg::REG_OVERRIDE_LAG_MS, lag);
	endtask

	// Waits until every sample is taken and every command has come back.
	task automatic wait_drain();
		while (taken_total != sent_total || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [11:0] to_pulse(int v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'd4095;
		return v[11:0];
	endfunction

	// Stick pulses: mostly near the center, some inside the override band, some anywhere.
	function automatic logic [11:0] stick_pulse();
		int pick, span, dev;
		pick = $urandom_range(0, 99);
		span = int'(reg_range) / 2 + 50;
		dev = int'(reg_deviation);
		if (pick < 50)
			return to_pulse(int'(reg_center) + int'($urandom_range(0, 2 * span)) - span);
		if (pick < 70)
			return to_pulse(int'(reg_center) + int'($urandom_range(0, 2 * dev)) - dev);
		if (pick < 90)
			return 12'($urandom_range(0, 4095));
		return pick[0] ? 12'd4095 : 12'd0;
	endfunction

	// Switch pulses: clearly low, clearly high, at the threshold, or anywhere.
	function automatic logic [11:0] switch_pulse();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return 12'($urandom_range(900, 1100));
		if (pick < 8)
			return 12'($urandom_range(1900, 2100));
		if (pick < 9)
			return 12'($urandom_range(1499, 1502));
		return 12'($urandom_range(0, 4095));
	endfunction

	// Queues random samples until the given number will pass the refresh check.
	task automatic run_random(input int count);
		int target, pick;
		logic [31:0] advance_us;
		logic [11:0] thr;
		target = plan_taken + count;
		while (plan_taken < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				advance_us = 20000 + $urandom_range(0, 3000);
			else if (pick < 80)
				advance_us = $urandom_range(0, 19999);
			else if (pick < 85)
				advance_us = 20000;
			else if (pick < 88)
				advance_us = 19999;
			else if (pick < 94)
				advance_us = $urandom_range(1000000, 70000000);
			else
				advance_us = $urandom();
			if ($urandom_range(0, 9) < 6)
				thr = to_pulse(int'(reg_bottom) + int'($urandom_range(0, reg_range)));
			else
				thr = stick_pulse();
			push_sample(clock_us + advance_us, stick_pulse(), stick_pulse(), stick_pulse(), thr,
				switch_pulse(), switch_pulse(), switch_pulse(), switch_pulse());
		end
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples on the reset settings: refresh edges, extremes, override lag, wrap.
		push_sample(32'd5000, 1500, 1500, 1500, 1000, 1000, 1000, 1000, 1000);
		push_sample(32'd20000, 1500, 1500, 1500, 1000, 1000, 1000, 1000, 1000);
		push_sample(32'd39999, 1500, 1500, 1500, 1000, 1000, 1000, 1000, 1000);
		push_sample(32'd40000, 4095, 0, 4095, 4095, 1501, 1501, 1000, 1000);
		push_sample(32'd60000, 0, 4095, 0, 0, 1500, 1500, 1501, 1501);
		push_sample(32'd80000, 2000, 1000, 1700, 2500, 4095, 4095, 4095, 4095);
		push_sample(32'd100000, 1500, 1500, 1500, 1500, 0, 0, 0, 0);
		push_sample(32'd2000000, 1600, 1400, 1500, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'd2020000, 1601, 1500, 1500, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'd2040000, 1500, 1500, 1500, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'd3020000, 1500, 1500, 1399, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'd3039999, 1500, 1500, 1500, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'hFFFF_C000, 1500, 1500, 1500, 1500, 2000, 2000, 1000, 2000);
		push_sample(32'h0000_0E20, 1450, 1550, 1500, 1200, 2000, 1000, 1000, 1000);
		push_sample(32'hFFFF_FFFF, 1500, 1500, 1500, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'h0000_4E1F, 1500, 1500, 1500, 1500, 1000, 1000, 1000, 1000);
		push_sample(32'h8000_0000, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
		push_sample(32'h8000_4E20, 0, 0, 0, 0, 0, 0, 0, 0);

		// Random phases, each on its own register setting; the last runs without idling.
		for (ph = 0; ph < 7; ph++) begin
			wait_drain();
			case (ph)
				0: program_regs(0, 4095, 4095, 4095, 16383, 131071, 4095, 65535);
				1: program_regs(0, 0, 0, 0, 0, 0, 0, 0);
				2: program_regs(1, 1500, 1000, 1000, 3219, 12868, 100, 200);
				3: program_regs(0, 1500, 1, 2000, 16383, 131071, 50, 0);
				6: program_regs(0, 1500, 1000, 1000, 3219, 12868, 100, 20);
				default: program_regs($urandom_range(0, 1), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 16383),
					$urandom_range(0, 131071), $urandom_range(0, 4095),
					$urandom_range(0, 65535));
			endcase
			if (ph == 6)
				quiet = 1'b1;
			run_random(PHASE_ITEMS);
		end

		wait_drain();
		if (mismatches == 0)
			$display("** rc_stick_command_interpreter_core: PASSED **");
		else
			$display("** rc_stick_command_interpreter_core: FAILED **");
		$finish;
	end

endmodule
